FILE: rtl/core/dplc_pkg.sv
package dplc_pkg;

	localparam int LED_COUNT = 5;
	localparam int IDX_W     = $clog2(LED_COUNT);
	localparam int ADDR_W    = 3;

	typedef enum logic [1:0] {
		CMD_MOVE     = 2'd0,
		CMD_DISTANCE = 2'd1,
		CMD_TICK     = 2'd2,
		CMD_REFRESH  = 2'd3
	} cmd_t;

	localparam logic REG_CHASE_STYLE = 1'b0;
	localparam logic REG_ARRIVE_DIST = 1'b1;

	localparam logic [8:0]  ANGLE_MAX      = 9'd360;
	localparam logic [8:0]  SERVO_MAX      = 9'd180;
	localparam logic [15:0] DIST_FAR       = 16'd2000;
	localparam logic [15:0] DIST_NEAR      = 16'd1000;
	localparam logic [7:0]  INTERVAL_FAR   = 8'd200;
	localparam logic [7:0]  INTERVAL_BASE  = 8'd50;
	localparam logic [7:0]  TIMER_MAX      = 8'd255;
	localparam logic [9:0]  ARRIVE_RESET   = 10'd15;
	localparam logic [16:0] RECIP_FIVE     = 17'd205;

	typedef struct packed {
		logic [LED_COUNT-1:0] lit;
		logic [IDX_W-1:0]     idx;
	} chase_t;

	// 50 + d*150/2000 = 50 + floor(floor(3d/8)/5), the divide by 5 by reciprocal
	function automatic logic [7:0] near_interval(input logic [9:0] d);
		logic [11:0] x;
		logic [8:0]  y;
		logic [16:0] p;
		x = {2'b00, d} + {1'b0, d, 1'b0};
		y = x[11:3];
		p = {8'd0, y} * RECIP_FIVE;
		return INTERVAL_BASE + {1'b0, p[16:10]};
	endfunction

endpackage

FILE: rtl/core/dplc_chase.sv
module dplc_chase (
	input  dplc_pkg::chase_t cur,
	input  logic             reverse,
	input  logic             fill,
	input  logic             arrived,
	output dplc_pkg::chase_t nxt
);
	import dplc_pkg::*;

	logic [IDX_W-1:0]     pos;
	logic [LED_COUNT-1:0] base;

	always_comb begin
		pos  = reverse ? IDX_W'(LED_COUNT - 1) - cur.idx : cur.idx;
		base = (!fill || cur.idx == '0) ? '0 : cur.lit;
		if (arrived) begin
			nxt.lit = '1;
			nxt.idx = cur.idx;
		end else begin
			nxt.lit = base | (LED_COUNT'(1) << pos);
			nxt.idx = (cur.idx == IDX_W'(LED_COUNT - 1)) ? '0 : cur.idx + IDX_W'(1);
		end
	end

endmodule

FILE: rtl/core/direction_pointer_led_chase.sv
// channel | signals                                          | direction
// input   | in_valid, in_stall, command, target_angle,       | item in
//         | target_distance                                  |
// output  | out_valid, out_stall, led_pattern, servo_angle,  | item out
//         | backwards, update_due, arrived                   |
// config  | psel, penable, pwrite, paddr, pwdata, prdata     | apb register port
//
// one item per cycle while the result is not stalled; an item passes the input register, then the result register
// state updates as an item moves from the input register to the result register
// arst_n resets the config, pointer state and valid flags, not the input or result data; no clearing pass
// a stalled result holds; the input register takes items unless it holds an item
// behind a stalled result
module direction_pointer_led_chase (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      command,
	input  logic [8:0]                      target_angle,
	input  logic [15:0]                     target_distance,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [dplc_pkg::LED_COUNT-1:0]  led_pattern,
	output logic [7:0]                      servo_angle,
	output logic                            backwards,
	output logic                            update_due,
	output logic                            arrived,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dplc_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import dplc_pkg::*;

	logic        chase_style_q;
	logic [9:0]  arrive_dist_q;

	logic        valid_s1;
	cmd_t        command_s1;
	logic [8:0]  angle_s1;
	logic [15:0] dist_s1;

	chase_t      chase_q;
	logic [8:0]  pending_angle_q;
	logic        angle_pending_q;
	logic        reverse_q;
	logic [7:0]  servo_q;
	logic        arrived_q;
	logic [7:0]  interval_q;
	logic [7:0]  elapsed_q;
	logic        timer_run_q;
	logic        out_valid_q;
	logic        due_q;

	logic        out_free;
	logic        advance;

	chase_t      chase_in;
	chase_t      chase_out;
	chase_t      chase_n;
	logic [8:0]  pending_angle_n;
	logic        angle_pending_n;
	logic        reverse_n;
	logic [7:0]  servo_n;
	logic        arrived_n;
	logic [7:0]  interval_n;
	logic [7:0]  elapsed_n;
	logic [7:0]  elapsed_inc;
	logic        timer_run_n;
	logic        due_n;

	assign pready   = 1'b1;
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign out_valid = out_valid_q;
	assign update_due = due_q;

	always_comb begin
		unique case (paddr[2])
			REG_CHASE_STYLE: prdata = {31'd0, chase_style_q};
			REG_ARRIVE_DIST: prdata = {22'd0, arrive_dist_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chase_style_q <= 1'b1;
			arrive_dist_q <= ARRIVE_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_CHASE_STYLE: chase_style_q <= pwdata[0];
				REG_ARRIVE_DIST: arrive_dist_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= cmd_t'(command);
			angle_s1   <= target_angle;
			dist_s1    <= target_distance;
		end
	end

	// pending angle applied ahead of the chase so the mirror sees the new direction
	always_comb begin
		pending_angle_n = pending_angle_q;
		angle_pending_n = angle_pending_q;
		reverse_n       = reverse_q;
		servo_n         = servo_q;
		arrived_n       = arrived_q;
		interval_n      = interval_q;
		elapsed_n       = elapsed_q;
		timer_run_n     = timer_run_q;
		due_n           = 1'b0;
		chase_in        = chase_q;
		elapsed_inc     = (elapsed_q != TIMER_MAX) ? elapsed_q + 8'd1 : elapsed_q;
		if (command_s1 == CMD_REFRESH && angle_pending_q) begin
			angle_pending_n = 1'b0;
			if (pending_angle_q > SERVO_MAX) begin
				servo_n   = 8'(pending_angle_q - SERVO_MAX);
				reverse_n = 1'b1;
			end else begin
				servo_n   = pending_angle_q[7:0];
				reverse_n = 1'b0;
			end
		end
		unique case (command_s1)
			CMD_MOVE: begin
				pending_angle_n = (angle_s1 > ANGLE_MAX) ? ANGLE_MAX : angle_s1;
				angle_pending_n = 1'b1;
			end
			CMD_DISTANCE: begin
				if (dist_s1 > DIST_FAR) begin
					interval_n = INTERVAL_FAR;
				end else if (dist_s1 < DIST_NEAR) begin
					interval_n = near_interval(dist_s1[9:0]);
				end
				if (dist_s1 < {6'd0, arrive_dist_q}) begin
					arrived_n = 1'b1;
				end
			end
			CMD_TICK: begin
				if (!timer_run_q) begin
					timer_run_n = 1'b1;
					elapsed_n   = '0;
				end else if (elapsed_inc >= interval_q) begin
					elapsed_n = '0;
					due_n     = 1'b1;
				end else begin
					elapsed_n = elapsed_inc;
				end
			end
			CMD_REFRESH: ;
			default: ;
		endcase
		chase_n = (command_s1 == CMD_REFRESH) ? chase_out : chase_q;
	end

	dplc_chase u_chase (
		.cur     (chase_in),
		.reverse (reverse_n),
		.fill    (chase_style_q),
		.arrived (arrived_q),
		.nxt     (chase_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chase_q         <= '0;
			pending_angle_q <= '0;
			angle_pending_q <= 1'b1;
			reverse_q       <= 1'b0;
			servo_q         <= '0;
			arrived_q       <= 1'b0;
			interval_q      <= INTERVAL_FAR;
			elapsed_q       <= '0;
			timer_run_q     <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (advance) begin
				chase_q         <= chase_n;
				pending_angle_q <= pending_angle_n;
				angle_pending_q <= angle_pending_n;
				reverse_q       <= reverse_n;
				servo_q         <= servo_n;
				arrived_q       <= arrived_n;
				interval_q      <= interval_n;
				elapsed_q       <= elapsed_n;
				timer_run_q     <= timer_run_n;
				out_valid_q     <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_pattern <= chase_n.lit;
			servo_angle <= servo_n;
			backwards   <= reverse_n;
			due_q       <= due_n;
			arrived     <= arrived_n;
		end
	end

`ifndef SYNTHESIS
	a_arrived_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		arrived_q |=> arrived_q)
		else $error("arrived latch cleared");

	a_servo_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> servo_angle <= SERVO_MAX[7:0])
		else $error("servo angle out of range");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		chase_q.idx <= IDX_W'(LED_COUNT - 1))
		else $error("chase index out of range");

	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a held result");

	a_due_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		advance && due_n |-> command_s1 == CMD_TICK && timer_run_q)
		else $error("update due outside a running tick");
`endif

endmodule

FILE: bench/tb_direction_pointer_led_chase.sv
module tb_direction_pointer_led_chase;
	import dplc_pkg::*;

	localparam logic [ADDR_W-1:0] ADDR_STYLE  = {REG_CHASE_STYLE, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_ARRIVE = {REG_ARRIVE_DIST, 2'b00};
	localparam int HOLD_CYCLES = 64;

	typedef struct packed {
		logic [LED_COUNT-1:0] leds;
		logic [7:0]           servo;
		logic                 back;
		logic                 due;
		logic                 arr;
	} pointer_view_t;

	typedef struct packed {
		cmd_t          c;
		logic [8:0]    a;
		logic [15:0]   d;
		logic          known;
		pointer_view_t want;
	} stim_row_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_style_t;

	typedef struct {
		logic         fill;
		logic [9:0]   arrive;
		int           items;
		int           dist_min;
		stall_style_t stall;
		bit           gaps;
		bit           press;
	} phase_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           command = 2'd0;
	logic [8:0]           target_angle = 9'd0;
	logic [15:0]          target_distance = 16'd0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [LED_COUNT-1:0] led_pattern;
	logic [7:0]           servo_angle;
	logic                 backwards;
	logic                 update_due;
	logic                 arrived;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [31:0]          pwdata = 32'd0;
	logic [31:0]          prdata;
	logic                 pready;

	direction_pointer_led_chase dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.target_angle(target_angle), .target_distance(target_distance),
		.out_valid(out_valid), .out_stall(out_stall), .led_pattern(led_pattern),
		.servo_angle(servo_angle), .backwards(backwards), .update_due(update_due),
		.arrived(arrived),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("direction_pointer_led_chase verification failed");
		$finish;
	end

	// pointer model state
	logic                 cfg_fill = 1'b1;
	logic [9:0]           cfg_arrive = ARRIVE_RESET;
	logic [LED_COUNT-1:0] lit = '0;
	int                   chase_pos = 0;
	logic [8:0]           goal_angle = 9'd0;
	logic                 goal_fresh = 1'b1;
	logic                 reverse = 1'b0;
	logic [7:0]           servo = 8'd0;
	logic                 arrived_seen = 1'b0;
	logic [7:0]           interval = INTERVAL_FAR;
	logic [7:0]           elapsed = 8'd0;
	logic                 timer_on = 1'b0;

	pointer_view_t pointer_expect[$];

	int  n_errors = 0;
	int  n_items = 0;
	int  n_results = 0;
	int  n_refresh = 0;
	int  n_due = 0;
	int  n_back = 0;
	int  n_arrived = 0;
	int  n_backpressure = 0;
	int  burst_left = 0;
	int  hold_left = 0;
	int  cyc = 0;
	bit  hold_req = 1'b0;
	bit  sender_gaps = 1'b0;
	stall_style_t stall_style = STALL_LIGHT;

	function automatic pointer_view_t step_pointer(cmd_t c, logic [8:0] a, logic [15:0] d);
		pointer_view_t r;
		int            pos;
		logic          due;
		due = 1'b0;
		case (c)
			CMD_MOVE: begin
				goal_angle = (a > ANGLE_MAX) ? ANGLE_MAX : a;
				goal_fresh = 1'b1;
			end
			CMD_DISTANCE: begin
				if (d > DIST_FAR)
					interval = INTERVAL_FAR;
				else if (d < DIST_NEAR)
					interval = INTERVAL_BASE + 8'((int'(d) * 150) / 2000);
				if (d < cfg_arrive)
					arrived_seen = 1'b1;
			end
			CMD_TICK: begin
				if (!timer_on) begin
					timer_on = 1'b1;
					elapsed = 8'd0;
				end else begin
					if (elapsed != TIMER_MAX)
						elapsed++;
					if (elapsed >= interval) begin
						elapsed = 8'd0;
						due = 1'b1;
					end
				end
			end
			default: begin
				if (goal_fresh) begin
					reverse = goal_angle > SERVO_MAX;
					servo = reverse ? 8'(goal_angle - SERVO_MAX) : goal_angle[7:0];
					goal_fresh = 1'b0;
				end
				if (arrived_seen) begin
					lit = '1;
				end else begin
					pos = reverse ? LED_COUNT - 1 - chase_pos : chase_pos;
					if (!cfg_fill || chase_pos == 0)
						lit = '0;
					lit[pos] = 1'b1;
					chase_pos = (chase_pos + 1) % LED_COUNT;
				end
			end
		endcase
		r.leds = lit;
		r.servo = servo;
		r.back = reverse;
		r.due = due;
		r.arr = arrived_seen;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			n_errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, seen);
		end
	endtask

	task automatic send_item(input cmd_t c, input logic [8:0] a, input logic [15:0] d,
			input logic known, input pointer_view_t want);
		pointer_view_t got;
		int            gap;
		if (sender_gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		command <= c;
		target_angle <= a;
		target_distance <= d;
		@(posedge clk);
		while (in_stall) begin
			n_backpressure++;
			@(posedge clk);
		end
		got = step_pointer(c, a, d);
		pointer_expect.push_back(known ? want : got);
		n_items++;
		if (c == CMD_REFRESH)
			n_refresh++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pointer_expect.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_reg(input logic idx, input logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] held;
		logic [ADDR_W-1:0] addr;
		addr = (idx == REG_CHASE_STYLE) ? ADDR_STYLE : ADDR_ARRIVE;
		if (idx == REG_CHASE_STYLE) begin
			cfg_fill = value[0];
			held = {31'd0, value[0]};
		end else begin
			cfg_arrive = value[9:0];
			held = {22'd0, value[9:0]};
		end
		apb_access(1'b1, addr, value, rd);
		apb_access(1'b0, addr, 32'd0, rd);
		compare_field("register readback", held, rd);
	endtask

	always @(posedge clk) begin
		pointer_view_t seen;
		pointer_view_t want;
		logic          hold_now;
		cyc++;
		if (arst_n && out_valid && !out_stall) begin
			seen = {led_pattern, servo_angle, backwards, update_due, arrived};
			if (pointer_expect.size() == 0) begin
				n_errors++;
				$display("%0t: result with no item outstanding, expected none got %h",
					$time, seen);
			end else begin
				want = pointer_expect.pop_front();
				compare_field("led_pattern", 32'(want.leds), 32'(seen.leds));
				compare_field("servo_angle", 32'(want.servo), 32'(seen.servo));
				compare_field("backwards", 32'(want.back), 32'(seen.back));
				compare_field("update_due", 32'(want.due), 32'(seen.due));
				compare_field("arrived", 32'(want.arr), 32'(seen.arr));
				n_results++;
				n_due += int'(want.due);
				n_back += int'(want.back);
				n_arrived += int'(want.arr);
			end
		end
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			hold_now = 1'b1;
		end else begin
			case (stall_style)
				STALL_NONE:     hold_now = 1'b0;
				STALL_LIGHT:    hold_now = $urandom_range(0, 99) < 30;
				STALL_PERIODIC: hold_now = (cyc % 5) < 2;
				default:        hold_now = $urandom_range(0, 99) < 70;
			endcase
		end
		out_stall <= hold_now;
	end

	stim_row_t directed_rows [0:24] = '{
		'{CMD_REFRESH,  9'd0,   16'd0,     1'b1, '{5'b00001, 8'd0, 1'b0, 1'b0, 1'b0}},
		'{CMD_TICK,     9'd0,   16'd0,     1'b1, '{5'b00001, 8'd0, 1'b0, 1'b0, 1'b0}},
		'{CMD_MOVE,     9'd511, 16'd65535, 1'b0, '0},
		'{CMD_REFRESH,  9'd0,   16'd0,     1'b0, '0},
		'{CMD_MOVE,     9'd360, 16'd0,     1'b0, '0},
		'{CMD_REFRESH,  9'd0,   16'd0,     1'b0, '0},
		'{CMD_MOVE,     9'd181, 16'd7,     1'b0, '0},
		'{CMD_REFRESH,  9'd0,   16'd0,     1'b0, '0},
		'{CMD_MOVE,     9'd180, 16'd0,     1'b0, '0},
		'{CMD_REFRESH,  9'd0,   16'd0,     1'b0, '0},
		'{CMD_MOVE,     9'd0,   16'd0,     1'b0, '0},
		'{CMD_REFRESH,  9'd0,   16'd0,     1'b0, '0},
		'{CMD_REFRESH,  9'd511, 16'd0,     1'b0, '0},
		'{CMD_DISTANCE, 9'd511, 16'd65535, 1'b0, '0},
		'{CMD_DISTANCE, 9'd0,   16'd2001,  1'b0, '0},
		'{CMD_DISTANCE, 9'd0,   16'd2000,  1'b0, '0},
		'{CMD_DISTANCE, 9'd0,   16'd1000,  1'b0, '0},
		'{CMD_DISTANCE, 9'd0,   16'd999,   1'b0, '0},
		'{CMD_DISTANCE, 9'd0,   16'd15,    1'b0, '0},
		'{CMD_TICK,     9'd511, 16'd0,     1'b0, '0},
		'{CMD_TICK,     9'd0,   16'd65535, 1'b0, '0},
		'{CMD_REFRESH,  9'd0,   16'd0,     1'b0, '0},
		'{CMD_MOVE,     9'd1,   16'd0,     1'b0, '0},
		'{CMD_MOVE,     9'd359, 16'd0,     1'b0, '0},
		'{CMD_REFRESH,  9'd0,   16'd0,     1'b0, '0}
	};

	phase_t phases [0:4] = '{
		'{1'b0, 10'd0,    300, 0,    STALL_LIGHT,    1'b1, 1'b1},
		'{1'b1, 10'd0,    300, 0,    STALL_NONE,     1'b0, 1'b0},
		'{1'b0, 10'd1000, 250, 1000, STALL_PERIODIC, 1'b1, 1'b0},
		'{1'b1, 10'd1,    150, 1,    STALL_HEAVY,    1'b1, 1'b0},
		'{1'b1, 10'd600,  200, 0,    STALL_LIGHT,    1'b1, 1'b0}
	};

	initial begin
		cmd_t        c;
		logic [8:0]  a;
		logic [15:0] d;
		int          r;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_item(directed_rows[i].c, directed_rows[i].a, directed_rows[i].d,
				directed_rows[i].known, directed_rows[i].want);
		drain_results();
		foreach (phases[p]) begin
			program_reg(REG_CHASE_STYLE, {31'd0, phases[p].fill});
			program_reg(REG_ARRIVE_DIST, {22'd0, phases[p].arrive});
			stall_style = phases[p].stall;
			sender_gaps = phases[p].gaps;
			if (phases[p].press)
				hold_req = 1'b1;
			repeat (phases[p].items) begin
				r = $urandom_range(0, 99);
				if (r < 50)
					c = CMD_TICK;
				else if (r < 75)
					c = CMD_REFRESH;
				else if (r < 90)
					c = CMD_MOVE;
				else
					c = CMD_DISTANCE;
				case ($urandom_range(0, 7))
					0:       a = 9'd0;
					1:       a = 9'd180 + 9'($urandom_range(0, 1));
					2:       a = 9'd360 + 9'($urandom_range(0, 1));
					default: a = 9'($urandom_range(0, 511));
				endcase
				case ($urandom_range(0, 4))
					0:       d = 16'($urandom_range(0, 65535));
					1, 2:    d = 16'($urandom_range(0, 999));
					3:       d = 16'($urandom_range(1000, 2000));
					default: d = 16'($urandom_range(2001, 65535));
				endcase
				if (d < phases[p].dist_min)
					d = 16'($urandom_range(phases[p].dist_min, 65535));
				send_item(c, a, d, 1'b0, '0);
			end
			drain_results();
		end
		repeat (10) @(posedge clk);
		$display("covered %0d items and %0d results: %0d refreshes, %0d due ticks,",
			n_items, n_results, n_refresh, n_due);
		$display("%0d backwards results, %0d arrived results, %0d cycles of input backpressure",
			n_back, n_arrived, n_backpressure);
		if (n_errors == 0)
			$display("direction_pointer_led_chase verification clean");
		else
			$display("direction_pointer_led_chase verification failed");
		$finish;
	end

endmodule
